[design/iil_pkg.sv]
// ----------------------------------------------------------------------------
// iil_pkg
// Shared constants, types and handshake codes for the interval index lookup.
// ----------------------------------------------------------------------------
package iil_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // field widths
    localparam int START_W     = 64;
    localparam int POS_W       = 32;
    localparam int SLOT_W      = 10;
    localparam int ID_W        = 10;
    localparam int CFG_CNT_W   = 11;

    // configuration port
    localparam int APB_ADDR_W  = 2;
    localparam int APB_DATA_W  = 32;
    localparam logic [CFG_CNT_W-1:0] ENTRY_COUNT_RESET = CFG_CNT_W'(1);

    // operation codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic wr_en;
        logic start;
        logic step;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic search_done;
        logic count_zero;
    } t_dp_status;

endpackage

[design/iil_ram.sv]
// ----------------------------------------------------------------------------
// iil_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module iil_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/iil_dp.sv]
// ----------------------------------------------------------------------------
// iil_dp
// Search datapath: start table, bound registers, midpoint logic and the
// result register.
// ----------------------------------------------------------------------------
module iil_dp (
    input  logic                          i_clk,
    input  iil_pkg::t_dp_cmd              i_cmd,
    input  logic [iil_pkg::CFG_CNT_W-1:0] i_entry_count,
    input  logic [iil_pkg::SLOT_W-1:0]    i_entry_index,
    input  logic [iil_pkg::START_W-1:0]   i_start_value,
    input  logic [iil_pkg::POS_W-1:0]     i_position,
    output iil_pkg::t_dp_status           o_status,
    output logic [iil_pkg::ID_W-1:0]      o_interval_id,
    output logic                          o_unmapped
);

    import iil_pkg::*;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_ZERO = '0;

    logic [CNT_W-1:0]   r_lo, r_hi, r_mid;
    logic [CNT_W-1:0]   n_lo, n_hi, n_mid;
    logic [POS_W-1:0]   r_pos;
    logic [ID_W-1:0]    r_interval_id;
    logic               r_unmapped;

    logic [CNT_W-1:0]   count_sat;
    logic               slot_ok;
    logic [START_W-1:0] rd_data;
    logic               le;
    logic [CNT_W-1:0]   mid_inc;
    logic [CNT_W-1:0]   mid_up, mid_dn;
    logic [CNT_W-1:0]   step_lo, step_hi, step_mid;

    // entry count saturates at the table depth
    assign count_sat = (32'(i_entry_count) > 32'(TABLE_DEPTH)) ?
                       CNT_W'(TABLE_DEPTH) : CNT_W'(i_entry_count);

    // slots beyond the table are dropped
    assign slot_ok = 32'(i_entry_index) < 32'(TABLE_DEPTH);

    // start table
    iil_ram #(
        .WIDTH (START_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en && slot_ok),
        .i_wr_addr (IDX_W'(i_entry_index)),
        .i_wr_data (i_start_value),
        .i_rd_addr (n_mid[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // compare the entry at the current midpoint
    assign le = rd_data <= {{(START_W-POS_W){1'b0}}, r_pos};

    // both candidate midpoints come from registers, the compare only selects
    assign mid_inc  = r_mid + CNT_ONE;
    assign mid_up   = mid_inc + ((r_hi - mid_inc) >> 1);
    assign mid_dn   = r_lo + ((r_mid - r_lo) >> 1);
    assign step_lo  = le ? mid_inc : r_lo;
    assign step_hi  = le ? r_hi : r_mid;
    assign step_mid = le ? mid_up : mid_dn;

    // next bounds, also drives the read address
    always_comb begin
        n_lo  = r_lo;
        n_hi  = r_hi;
        n_mid = r_mid;
        if (i_cmd.start) begin
            n_lo  = CNT_ZERO;
            n_hi  = count_sat;
            n_mid = count_sat >> 1;
        end else if (i_cmd.step) begin
            n_lo  = step_lo;
            n_hi  = step_hi;
            n_mid = step_mid;
        end
    end

    // bound and position registers
    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        if (i_cmd.start) begin
            r_pos <= i_position;
        end
    end

    // result register, lo holds the upper bound once the search ends
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_unmapped    <= (r_lo == CNT_ZERO);
            r_interval_id <= (r_lo == CNT_ZERO) ? '0 : ID_W'(r_lo - CNT_ONE);
        end
    end

    assign o_status.search_done = (step_lo == step_hi);
    assign o_status.count_zero  = (count_sat == CNT_ZERO);
    assign o_interval_id        = r_interval_id;
    assign o_unmapped           = r_unmapped;

endmodule

[design/iil_ctrl.sv]
// ----------------------------------------------------------------------------
// iil_ctrl
// Controller: request acceptance, search sequencing and result valid.
// ----------------------------------------------------------------------------
module iil_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_func,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    input  iil_pkg::t_dp_status i_status,
    output iil_pkg::t_dp_cmd    o_cmd
);

    import iil_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;

    // state and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_stall      = 1'b1;
        n_out_valid  = r_out_valid && i_stall;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_func == FUNC_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_state = i_status.count_zero ? S_FINISH : S_SEARCH;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                    end
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_status.search_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

[design/interval_index_lookup.sv]
// ----------------------------------------------------------------------------
// interval_index_lookup
// Maps a position to the index of the last ascending interval start at or
// below it, searching a table loaded through write requests.
// ----------------------------------------------------------------------------
// A write request stores one 64-bit start into the table. A query request
// binary-searches the first entry_count starts (saturated at the table depth)
// in at most ceil(log2(count + 1)) search steps, 11 for a full table of 1024.
// Each step is one read of the table RAM through its single registered read
// port, with the next midpoint chosen in the same cycle as the compare. A
// query whose position lies below the first start returns index 0 with the
// unmapped flag set. The result register frees the input side: the next
// request is taken while a result still waits. The table is not cleared at
// reset; starts must be written before a query reaches them, and
// entry_count may be changed only while the block is idle.
// ----------------------------------------------------------------------------
module interval_index_lookup (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_func,
    input  logic [iil_pkg::SLOT_W-1:0]     i_entry_index,
    input  logic [iil_pkg::START_W-1:0]    i_start_value,
    input  logic [iil_pkg::POS_W-1:0]      i_position,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [iil_pkg::ID_W-1:0]       o_interval_id,
    output logic                           o_unmapped,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iil_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [iil_pkg::APB_DATA_W-1:0] pwdata,
    output logic [iil_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    import iil_pkg::*;

    logic [CFG_CNT_W-1:0] r_entry_count;
    logic                 cfg_wr;
    t_dp_cmd              cmd;
    t_dp_status           status;

    // single register, seen at every offset: the address is not decoded
    assign cfg_wr = psel && penable && pwrite && (paddr == '0 || paddr != '0);
    assign pready = 1'b1;
    assign prdata = {{(APB_DATA_W-CFG_CNT_W){1'b0}}, r_entry_count};

    // entry count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= ENTRY_COUNT_RESET;
        end else if (cfg_wr) begin
            r_entry_count <= pwdata[CFG_CNT_W-1:0];
        end
    end

    // controller
    iil_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath
    iil_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_entry_count (r_entry_count),
        .i_entry_index (i_entry_index),
        .i_start_value (i_start_value),
        .i_position    (i_position),
        .o_status      (status),
        .o_interval_id (o_interval_id),
        .o_unmapped    (o_unmapped)
    );

endmodule

[tb/sv/tb_interval_index_lookup.sv]
// ----------------------------------------------------------------------------
// tb_interval_index_lookup
// Self-checking bench for the interval index lookup block. A queue-fed driver
// sends table writes and position queries in random bursts, a monitor with its
// own stall pattern checks every result against a cycle-free lookup predictor,
// and the entry count is reprogrammed over APB between drained phases.
// ----------------------------------------------------------------------------
module tb_interval_index_lookup;

    import iil_pkg::*;

    localparam logic [APB_ADDR_W-1:0] REG_ENTRY_COUNT = '0;
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_LIMIT    = 5000;
    localparam int RAND_ITEMS    = 700;

    // starts on the full-depth search paths: base plus index times step
    localparam logic [START_W-1:0] PATH_BASE = 64'd100;
    localparam logic [START_W-1:0] PATH_STEP = 64'd1000;
    localparam logic [POS_W-1:0]   PATH_TOP  =
        POS_W'(PATH_BASE + START_W'(TABLE_DEPTH - 1) * PATH_STEP);

    typedef struct {
        logic                func;
        logic [SLOT_W-1:0]   slot;
        logic [START_W-1:0]  start;
        logic [POS_W-1:0]    pos;
    } t_lookup_req;

    typedef struct {
        logic [ID_W-1:0] id;
        logic            unmapped;
    } t_lookup_res;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // request channel
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic                i_func        = FUNC_WRITE;
    logic [SLOT_W-1:0]   i_entry_index = '0;
    logic [START_W-1:0]  i_start_value = '0;
    logic [POS_W-1:0]    i_position    = '0;

    // result channel
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic [ID_W-1:0]     o_interval_id;
    logic                o_unmapped;

    // configuration port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // bench state
    t_lookup_req          pending_requests[$];
    t_lookup_res          expected_lookups[$];
    logic [START_W-1:0]   shadow_starts[TABLE_DEPTH];
    logic [CFG_CNT_W-1:0] shadow_count = ENTRY_COUNT_RESET;
    logic [START_W-1:0]   phase_starts[TABLE_DEPTH];

    int errors      = 0;
    int n_writes    = 0;
    int n_queries   = 0;
    int n_results   = 0;
    int n_unmapped  = 0;
    int n_settings  = 0;
    int rand_items  = 0;

    interval_index_lookup DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_entry_index (i_entry_index),
        .i_start_value (i_start_value),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_interval_id (o_interval_id),
        .o_unmapped    (o_unmapped),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // upper bound search over the shadow table, minus one
    function automatic t_lookup_res find_interval(logic [POS_W-1:0] pos);
        int          lo;
        int          hi;
        int          mid;
        t_lookup_res r;
        lo = 0;
        hi = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_starts[mid] <= {{(START_W-POS_W){1'b0}}, pos})
                lo = mid + 1;
            else
                hi = mid;
        end
        if (lo == 0) begin
            r.id       = '0;
            r.unmapped = 1'b1;
        end else begin
            r.id       = ID_W'(lo - 1);
            r.unmapped = 1'b0;
        end
        return r;
    endfunction

    // request driver: bursts with random gaps, payload held while stalled
    int burst_left = 1;
    int gap_left   = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                if (i_func == FUNC_WRITE) begin
                    shadow_starts[i_entry_index] = i_start_value;
                    n_writes++;
                end else begin
                    expected_lookups.insert(expected_lookups.size(),
                                            find_interval(i_position));
                    n_queries++;
                end
                void'(pending_requests.pop_front());
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    i_valid       <= 1'b1;
                    i_func        <= pending_requests[0].func;
                    i_entry_index <= pending_requests[0].slot;
                    i_start_value <= pending_requests[0].start;
                    i_position    <= pending_requests[0].pos;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result stall pattern: free running, light, heavy and long stretches
    int stall_mode = 0;
    int mode_left  = 0;
    int hold_left  = 0;
    logic hold_val = 1'b0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (hold_left == 0) begin
                    hold_val  = ~hold_val;
                    hold_left = $urandom_range(1, 30);
                end else begin
                    hold_left--;
                end
                i_stall <= hold_val;
            end
        endcase
    end

    // result checker
    t_lookup_res got_exp;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (expected_lookups.size() == 0) begin
                $error("unexpected result: interval_id %0d unmapped %0b",
                       o_interval_id, o_unmapped);
                errors++;
            end else begin
                got_exp = expected_lookups.pop_front();
                if (got_exp.unmapped)
                    n_unmapped++;
                if (o_interval_id !== got_exp.id) begin
                    $error("interval_id mismatch: expected %0d, actual %0d",
                           got_exp.id, o_interval_id);
                    errors++;
                end
                if (o_unmapped !== got_exp.unmapped) begin
                    $error("unmapped mismatch: expected %0b, actual %0b",
                           got_exp.unmapped, o_unmapped);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [START_W-1:0] rand_start();
        return {$urandom, $urandom};
    endfunction

    task automatic push_write(input int slot, input logic [START_W-1:0] value);
        t_lookup_req r;
        r.func  = FUNC_WRITE;
        r.slot  = SLOT_W'(slot);
        r.start = value;
        r.pos   = $urandom;
        pending_requests.insert(pending_requests.size(), r);
        rand_items++;
    endtask

    task automatic push_query(input logic [POS_W-1:0] pos);
        t_lookup_req r;
        r.func  = FUNC_QUERY;
        r.slot  = SLOT_W'($urandom);
        r.start = rand_start();
        r.pos   = pos;
        pending_requests.insert(pending_requests.size(), r);
        rand_items++;
    endtask

    // wait until every request is taken and every result is back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || i_valid || expected_lookups.size() != 0);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        data = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // reprogram the entry count once the block has gone quiet
    task automatic set_entry_count(input int count);
        logic [APB_DATA_W-1:0] rd;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        apb_write(REG_ENTRY_COUNT, APB_DATA_W'(count));
        shadow_count = CFG_CNT_W'(count);
        n_settings++;
        apb_read(REG_ENTRY_COUNT, rd);
        if (rd !== APB_DATA_W'(shadow_count)) begin
            $error("entry_count readback mismatch: expected %0d, actual %0d",
                   shadow_count, rd);
            errors++;
        end
        @(negedge i_clk);
    endtask

    // fill the first count slots: ascending in several ranges, or scrambled
    task automatic load_table(input int count, input bit full_span);
        int                 mode;
        int                 i;
        logic [START_W-1:0] v;
        logic [START_W-1:0] max_step;
        mode = full_span ? 4 : $urandom_range(0, 9);
        case (mode)
            0, 1, 2, 3: begin
                v        = $urandom_range(0, 50);
                max_step = 40;
            end
            4, 5, 6: begin
                v        = full_span ? $urandom_range(0, 1000) : $urandom;
                max_step = full_span ? 4000000 : (64'd1 << $urandom_range(4, 26));
            end
            default: begin
                v        = 64'hFFFF_F000 + $urandom_range(0, 4095);
                max_step = 4096;
            end
        endcase
        for (i = 0; i < count; i++) begin
            if (mode >= 8)
                v = ($urandom_range(0, 1) == 0) ? {32'h0, $urandom} : rand_start();
            phase_starts[i] = v;
            push_write(i, v);
            if (mode < 8)
                v = v + {32'h0, $urandom_range(0, int'(max_step))};
        end
    endtask

    // only the entries visited by searches below the first and above the last start
    task automatic load_search_paths();
        int                 lo;
        int                 hi;
        int                 mid;
        int                 pass;
        logic [START_W-1:0] v;
        for (pass = 0; pass < 2; pass++) begin
            lo = 0;
            hi = TABLE_DEPTH;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                v   = PATH_BASE + START_W'(mid) * PATH_STEP;
                phase_starts[mid] = v;
                push_write(mid, v);
                if (pass == 0)
                    hi = mid;
                else
                    lo = mid + 1;
            end
        end
    endtask

    // positions below the lowest or at and above the highest path start
    task automatic run_edge_queries(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 1) == 0)
                push_query(POS_W'($urandom_range(0, int'(PATH_BASE) - 1)));
            else
                push_query(POS_W'($urandom_range(PATH_TOP, 32'hFFFF_FFFF)));
        end
    endtask

    // positions around stored starts, at the extremes, or anywhere
    function automatic logic [POS_W-1:0] pick_position(input int count);
        int sel;
        sel = $urandom_range(0, 9);
        if (count == 0 || sel >= 8)
            return $urandom;
        if (sel < 5)
            return phase_starts[$urandom_range(0, count - 1)][POS_W-1:0]
                   + POS_W'($urandom_range(0, 2)) - POS_W'(1);
        if (sel == 5)
            return '0;
        if (sel == 6)
            return '1;
        return phase_starts[0][POS_W-1:0] - POS_W'(1);
    endfunction

    task automatic run_queries(input int count, input int n);
        int k;
        int r;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 19);
            if (r == 0 && count > 0) begin
                // overwrite a live slot, possibly breaking the ordering
                phase_starts[0] = phase_starts[0];
                push_write($urandom_range(0, count - 1), {32'h0, $urandom});
            end else if (r == 1 && count < TABLE_DEPTH) begin
                // slot outside the searched range
                push_write($urandom_range(count, TABLE_DEPTH - 1), rand_start());
            end else begin
                push_query(pick_position(count));
            end
        end
    endtask

    int count;
    int sel;
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single entry at reset count: below, at and above the start
        push_write(0, 64'd100);
        push_query(32'd99);
        push_query(32'd100);
        push_query(32'd0);
        push_query(32'hFFFF_FFFF);
        // a start beyond any 32-bit position
        push_write(0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_query(32'hFFFF_FFFF);
        // zero start maps position zero
        push_write(0, 64'd0);
        push_query(32'd0);

        // zero entry count: everything unmapped
        set_entry_count(0);
        push_query(32'd0);
        push_query(32'hFFFF_FFFF);

        // four entries with a duplicate, plus a write to the top slot
        set_entry_count(4);
        push_write(0, 64'd10);
        push_write(1, 64'd20);
        push_write(2, 64'd20);
        push_write(3, 64'd30);
        push_write(TABLE_DEPTH - 1, 64'hFFFF_FFFF_FFFF_FFFF);
        push_query(32'd9);
        push_query(32'd10);
        push_query(32'd20);
        push_query(32'd29);
        push_query(32'd30);
        push_query(32'hFFFF_FFFF);

        // random phases, mostly short tables
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                count = 0;
            else if (sel < 15)
                count = $urandom_range(1, 16);
            else if (sel < 19)
                count = $urandom_range(17, 128);
            else
                count = $urandom_range(129, 300);
            set_entry_count(count);
            load_table(count, 1'b0);
            run_queries(count, $urandom_range(8, 30));
        end

        // deepest searches at full depth, then saturating counts
        set_entry_count(TABLE_DEPTH);
        load_search_paths();
        run_edge_queries(20);
        set_entry_count(TABLE_DEPTH + 1);
        run_edge_queries(10);
        set_entry_count((1 << CFG_CNT_W) - 1);
        run_edge_queries(10);
        set_entry_count(1);
        run_queries(1, 10);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (expected_lookups.size() != 0) begin
            $error("%0d expected results never arrived", expected_lookups.size());
            errors++;
        end

        $display("run covered %0d table writes and %0d queries over %0d entry_count settings",
                 n_writes, n_queries, n_settings);
        $display("%0d results checked, %0d of them unmapped, %0d errors",
                 n_results, n_unmapped, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
design/iil_pkg.sv
design/iil_ram.sv
design/iil_dp.sv
design/iil_ctrl.sv
design/interval_index_lookup.sv
tb/sv/tb_interval_index_lookup.sv
